// ===== hdl/dcds_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the draw command depth sorter.
package dcds_pkg;

   // Default store depth in records
   localparam int CAPACITY_DEFAULT = 64;

   // Fixed field widths
   localparam int DEPTH_W     = 32;
   localparam int ID_W        = 32;
   localparam int TIE_KEY_W   = 64;
   localparam int POSITION_W  = 6;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Byte address word index of the sort mode register
   localparam logic REG_SORT_MODE = 1'b0;

   typedef enum logic [1:0] {
      MODE_NONE          = 2'd0,
      MODE_FRONT_TO_BACK = 2'd1,
      MODE_BACK_TO_FRONT = 2'd2,
      MODE_BY_MATERIAL   = 2'd3
   } sort_mode_type;

   // One stored draw command record
   typedef struct packed {
      logic signed [DEPTH_W-1:0] depth;
      logic [ID_W-1:0]           material_id;
      logic [ID_W-1:0]           object_id;
      logic [TIE_KEY_W-1:0]      tie_key;
   } record_type;

endpackage

// ===== hdl/dcds_order_cmp.sv =====
`timescale 1ns / 1ps
// Shared record order comparator: true when the candidate goes strictly before the held record.
module dcds_order_cmp (
   input  dcds_pkg::sort_mode_type mode,
   input  dcds_pkg::record_type    cand,
   input  dcds_pkg::record_type    held,
   output logic                    cand_before
);

   logic dep_lt, dep_gt, dep_eq;
   logic mat_lt, mat_eq;
   logic obj_lt, obj_eq;
   logic tk_lt, tk_gt;

   // Field compares, all in parallel
   always_comb begin
      dep_lt = cand.depth < held.depth;
      dep_gt = cand.depth > held.depth;
      dep_eq = cand.depth == held.depth;
      mat_lt = cand.material_id < held.material_id;
      mat_eq = cand.material_id == held.material_id;
      obj_lt = cand.object_id < held.object_id;
      obj_eq = cand.object_id == held.object_id;
      tk_lt  = cand.tie_key < held.tie_key;
      tk_gt  = cand.tie_key > held.tie_key;
   end

   // Lexical order per mode; no mode ever reports a tie as before
   always_comb begin
      case (mode)
         dcds_pkg::MODE_BY_MATERIAL: begin
            cand_before = mat_lt;
         end
         dcds_pkg::MODE_FRONT_TO_BACK: begin
            if (!dep_eq)
               cand_before = dep_lt;
            else if (!mat_eq)
               cand_before = mat_lt;
            else if (!obj_eq)
               cand_before = obj_lt;
            else
               cand_before = tk_lt;
         end
         dcds_pkg::MODE_BACK_TO_FRONT: begin
            if (!dep_eq)
               cand_before = dep_gt;
            else if (!mat_eq)
               cand_before = mat_lt;
            else if (!obj_eq)
               cand_before = obj_lt;
            else
               cand_before = tk_gt;
         end
         default: begin
            cand_before = 1'b0;
         end
      endcase
   end

endmodule

// ===== hdl/draw_command_depth_sorter_unit.sv =====
`timescale 1ns / 1ps
// Draw command depth sorter: loads a set of records, then emits them in stable sorted order.
// Loading: one record per cycle until the record marked last; then the input stalls.
// Emission of a set: each result costs one scan of the store through the single comparator,
// then a drain and an emit state; the emit waits while the output is stalled, and loading
// resumes after the last result. Reset clears the sequencer, count, overflow flag, mode and
// output valid; store contents are undefined until written.
module draw_command_depth_sorter_unit #(
   parameter int CAPACITY = dcds_pkg::CAPACITY_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // record input
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [dcds_pkg::DEPTH_W-1:0]    req_depth,
   input  logic [dcds_pkg::ID_W-1:0]              req_material_id,
   input  logic [dcds_pkg::ID_W-1:0]              req_object_id,
   input  logic [dcds_pkg::TIE_KEY_W-1:0]         req_tie_key,
   input  logic                                   req_last_in,
   // sorted output
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [dcds_pkg::DEPTH_W-1:0]    rsp_depth_out,
   output logic [dcds_pkg::ID_W-1:0]              rsp_material_out,
   output logic [dcds_pkg::ID_W-1:0]              rsp_object_out,
   output logic [dcds_pkg::TIE_KEY_W-1:0]         rsp_tie_key_out,
   output logic [dcds_pkg::POSITION_W-1:0]        rsp_load_position,
   output logic                                   rsp_last_out,
   output logic                                   rsp_overflowed,
   // register port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [dcds_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [dcds_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [dcds_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   dcds_pkg::sort_mode_type csr_mode_ff, csr_mode_in;
   dcds_pkg::sort_mode_type mode_ff, mode_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   logic [CNT_W-1:0]        scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]        emit_cnt_ff, emit_cnt_in;
   logic [CAPACITY-1:0]     emitted_ff, emitted_in;

   // registered read port of the store
   logic                    rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]        rd_pos_ff;
   dcds_pkg::record_type    rd_data_ff;

   // best record found so far in the current scan
   logic                    have_best_ff, have_best_in;
   dcds_pkg::record_type    best_ff, best_in;
   logic [IDX_W-1:0]        best_pos_ff, best_pos_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   dcds_pkg::record_type    out_rec_ff, out_rec_in;
   logic [IDX_W-1:0]        out_pos_ff, out_pos_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_ovf_ff, out_ovf_in;

   dcds_pkg::record_type    store_mem [CAPACITY];
   dcds_pkg::record_type    req_rec;
   logic                    in_xfer, store_wr, cand_before, out_free, csr_wr;
   logic [IDX_W-1:0]        scan_addr;

   assign req_rec   = '{depth: req_depth, material_id: req_material_id,
                        object_id: req_object_id, tie_key: req_tie_key};
   assign req_stall = (state_ff != ST_LOAD);
   assign in_xfer   = req_valid && !req_stall;
   assign store_wr  = in_xfer && (count_ff < CAP_CNT);
   assign scan_addr = scan_idx_ff[IDX_W-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      csr_mode_in = csr_mode_ff;
      if (csr_wr && (csr_paddr[2] == dcds_pkg::REG_SORT_MODE))
         csr_mode_in = dcds_pkg::sort_mode_type'(csr_pwdata[1:0]);
      csr_prdata = '0;
      if (csr_paddr[2] == dcds_pkg::REG_SORT_MODE)
         csr_prdata = dcds_pkg::CSR_DATA_W'(csr_mode_ff);
   end

   // Shared comparator: fetched record against best so far
   dcds_order_cmp u_cmp (
      .mode        (mode_ff),
      .cand        (rd_data_ff),
      .held        (best_ff),
      .cand_before (cand_before)
   );

   // Record store: one write port for loading, one registered read port for scanning
   always_ff @(posedge clock) begin
      if (store_wr)
         store_mem[count_ff[IDX_W-1:0]] <= req_rec;
      rd_data_ff <= store_mem[scan_addr];
      rd_pos_ff  <= scan_addr;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      scan_idx_in  = scan_idx_ff;
      emit_cnt_in  = emit_cnt_ff;
      emitted_in   = emitted_ff;
      rd_vld_in    = 1'b0;
      have_best_in = have_best_ff;
      best_in      = best_ff;
      best_pos_in  = best_pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_rec_in   = out_rec_ff;
      out_pos_in   = out_pos_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;

      // compare stage: keep the earliest record that nothing beats
      if (rd_vld_ff && !emitted_ff[rd_pos_ff] && (!have_best_ff || cand_before)) begin
         have_best_in = 1'b1;
         best_in      = rd_data_ff;
         best_pos_in  = rd_pos_ff;
      end

      case (state_ff)
         ST_LOAD: begin
            if (in_xfer) begin
               if (store_wr)
                  count_in = count_ff + 1'b1;
               else
                  ovf_in = 1'b1;
               if (req_last_in) begin
                  mode_in      = csr_mode_ff;
                  scan_idx_in  = '0;
                  emit_cnt_in  = '0;
                  have_best_in = 1'b0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_vld_in   = 1'b1;
            scan_idx_in = scan_idx_ff + 1'b1;
            if (scan_idx_ff == count_ff - 1'b1)
               state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               out_rec_in              = best_ff;
               out_pos_in              = best_pos_ff;
               out_last_in             = (emit_cnt_ff == count_ff - 1'b1);
               out_ovf_in              = ovf_ff;
               emitted_in[best_pos_ff] = 1'b1;
               emit_cnt_in             = emit_cnt_ff + 1'b1;
               have_best_in            = 1'b0;
               scan_idx_in             = '0;
               if (emit_cnt_ff == count_ff - 1'b1) begin
                  count_in   = '0;
                  ovf_in     = 1'b0;
                  emitted_in = '0;
                  state_in   = ST_LOAD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         csr_mode_ff  <= dcds_pkg::MODE_NONE;
         mode_ff      <= dcds_pkg::MODE_NONE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         scan_idx_ff  <= '0;
         emit_cnt_ff  <= '0;
         emitted_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         have_best_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_mode_ff  <= csr_mode_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         scan_idx_ff  <= scan_idx_in;
         emit_cnt_ff  <= emit_cnt_in;
         emitted_ff   <= emitted_in;
         rd_vld_ff    <= rd_vld_in;
         have_best_ff <= have_best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_pos_ff <= best_pos_in;
      out_rec_ff  <= out_rec_in;
      out_pos_ff  <= out_pos_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_depth_out     = out_rec_ff.depth;
   assign rsp_material_out  = out_rec_ff.material_id;
   assign rsp_object_out    = out_rec_ff.object_id;
   assign rsp_tie_key_out   = out_rec_ff.tie_key;
   assign rsp_load_position = dcds_pkg::POSITION_W'(out_pos_ff);
   assign rsp_last_out      = out_last_ff;
   assign rsp_overflowed    = out_ovf_ff;

   // Every scan must have found a record not yet emitted
   a_best_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> have_best_ff)
      else $error("emit without a selected record");

   // Emitted marks track the number of results sent in this set
   a_emit_marks: assert property (@(posedge clock) disable iff (reset)
      $countones(emitted_ff) == emit_cnt_ff || state_ff == ST_LOAD)
      else $error("emitted marks out of step with emit count");

   // Store count never passes capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("record count beyond capacity");

endmodule
